[design/prefix_expression_stack_evaluator_core_macros.svh]
// Assertion helpers used by the evaluator core.
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_CORE_MACROS_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_CORE_MACROS_SVH

`define PESE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PESE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pese_pkg.sv]
`timescale 1ns / 1ps
package pese_pkg;

  localparam logic [7:0] SymEnd   = 8'h23;
  localparam logic [7:0] SymPow   = 8'h5e;
  localparam logic [7:0] SymDiv   = 8'h2f;
  localparam logic [7:0] SymMul   = 8'h2a;
  localparam logic [7:0] SymAdd   = 8'h2b;
  localparam logic [7:0] SymSub   = 8'h2d;
  localparam logic [7:0] SymZero  = 8'h30;
  localparam logic [7:0] SymNine  = 8'h39;
  localparam logic [7:0] SymLowA  = 8'h61;
  localparam logic [7:0] SymLowZ  = 8'h7a;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StInvalid   = 3'd1;
  localparam logic [2:0] StOverflow  = 3'd2;
  localparam logic [2:0] StUnderflow = 3'd3;
  localparam logic [2:0] StDivZero   = 3'd4;
  localparam logic [2:0] StSat       = 3'd5;

  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = -32'sh7fff_ffff - 32'sd1;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture input request
    logic pop_x;      // issue read of top entry
    logic take_x;     // latch read data as x
    logic take_y;     // latch read data as y
    logic alu_start;  // start arithmetic
    logic push;       // write result
    logic clear;      // empty stack
    logic pop_res;    // pop final result
    logic load_out;   // register output
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_push;
    logic is_op;
    logic is_end;
    logic alu_done;
  } dp_sts_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v,
                                               output logic sat);
    sat = 1'b0;
    if (v > 64'(QMax)) begin
      sat = 1'b1;
      return QMax;
    end else if (v < 64'(QMin)) begin
      sat = 1'b1;
      return QMin;
    end
    return v[31:0];
  endfunction

endpackage

[design/prefix_expression_stack_evaluator_core.sv]
`timescale 1ns / 1ps
// channel    | dir | signals                        | request
// s_axis     | in  | tvalid tready tdata[39:0]      | symbol, var_value
// m_axis     | out | tvalid tready tdata[47:0]      | top_value, depth, status
//            |     | tuser[0]                       | done_res
// One request at a time; / runs a 48-step divider, and ^ with n = floor(y) clamped
// to MAX_EXP runs n-1 multiplies.
// Reset empties the stack; stack memory contents are not cleared.
// A held result lets one more request in; that request waits before its output load.
module prefix_expression_stack_evaluator_core #(
  parameter int STACK_DEPTH = 32,
  parameter int MAX_EXP = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // symbol[7:0], var_value[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // top_value[31:0], depth[37:32], status[40:38]
  output logic        m_axis_tuser    // done_res
);
  import pese_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [31:0] top_value;
  logic [5:0] depth;
  logic [2:0] status;

  pese_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  pese_datapath #(.StackDepth(STACK_DEPTH), .MaxExp(MAX_EXP)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .symbol_i(s_axis_tdata[7:0]), .var_value_i(s_axis_tdata[39:8]),
    .top_value_o(top_value), .depth_o(depth), .done_res_o(m_axis_tuser),
    .status_o(status)
  );

  assign m_axis_tdata = {7'b0, status, depth, top_value};

`include "prefix_expression_stack_evaluator_core_macros.svh"

  `PESE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "held result changed")
  `PESE_ASSERT_IMP(a_done_depth, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[37:32] == 6'd0, "stack not emptied at end")
  `PESE_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request while busy")
endmodule

[design/pese_alu.sv]
`timescale 1ns / 1ps
module pese_alu #(
  parameter int MaxExp = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pese_pkg::op_e       op_i,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  output logic                done_o,
  output logic signed [31:0]  res_o,
  output logic                sat_o,
  output logic                dz_o
);
  import pese_pkg::*;

  localparam int CntW = $clog2(MaxExp + 1) + 1;
  localparam int DivW = 48;

  localparam logic [1:0] AIdle = 2'd0;
  localparam logic [1:0] ADiv  = 2'd1;
  localparam logic [1:0] AMulA = 2'd2;
  localparam logic [1:0] AMulB = 2'd3;

  logic [1:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [31:0] res_q, res_d;
  logic sat_q, sat_d, dz_q, dz_d, done_q, done_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic neg_q, neg_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] base_q, base_d;

  logic signed [63:0] sum_w;
  logic signed [63:0] shq_w;
  logic [32:0] rsh_w;
  logic [33:0] rsub_w;
  logic [DivW:0] qabs_w;
  logic signed [63:0] qs_w;
  logic sat_w;
  logic signed [31:0] satv_w;
  logic [31:0] xabs_w, yabs_w;
  logic signed [63:0] yflr_w;

  always_comb begin
    xabs_w = x_i[31] ? 32'(-x_i) : 32'(x_i);
    yabs_w = y_i[31] ? 32'(-y_i) : 32'(y_i);
    yflr_w = 64'(y_i) >>> 16;
    rsh_w  = {rem_q[31:0], quo_q[DivW-1]};
    rsub_w = {1'b0, rsh_w} - {2'b00, dvs_q};
    shq_w  = prod_q >>> 16;
    qabs_w = {1'b0, quo_q};
    qs_w   = neg_q ? -64'(qabs_w) : 64'(qabs_w);
    sum_w  = '0;
    st_d = st_q; cnt_d = cnt_q; res_d = res_q; sat_d = sat_q; dz_d = dz_q;
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; neg_d = neg_q;
    prod_d = prod_q; base_d = base_q; done_d = 1'b0;
    satv_w = sat64(shq_w, sat_w);
    unique case (st_q)
      AIdle: begin
        if (start_i) begin
          sat_d = 1'b0; dz_d = 1'b0;
          unique case (op_i)
            OP_ADD, OP_SUB: begin
              sum_w = (op_i == OP_ADD) ? 64'(x_i) + 64'(y_i) : 64'(x_i) - 64'(y_i);
              res_d = sat64(sum_w, sat_d);
              done_d = 1'b1;
            end
            OP_MUL: begin
              prod_d = 64'(x_i) * 64'(y_i);
              cnt_d = '0;
              base_d = y_i;
              st_d = AMulB;
            end
            OP_DIV: begin
              if (y_i == '0) begin
                dz_d = 1'b1; res_d = '0; done_d = 1'b1;
              end else begin
                quo_d = {xabs_w, 16'h0};
                rem_d = '0;
                dvs_d = yabs_w;
                neg_d = x_i[31] ^ y_i[31];
                cnt_d = CntW'(0);
                st_d = ADiv;
              end
            end
            default: begin
              if (x_i == '0) begin
                res_d = '0; done_d = 1'b1;
              end else if (y_i == '0) begin
                res_d = QOne; done_d = 1'b1;
              end else if (y_i < 2 * QOne) begin
                res_d = x_i; done_d = 1'b1;
              end else begin
                // multiplies remaining = n-1
                if (yflr_w > 64'(MaxExp)) cnt_d = CntW'(MaxExp - 1);
                else cnt_d = CntW'(yflr_w - 64'sd1);
                res_d = x_i;
                base_d = x_i;
                st_d = AMulA;
              end
            end
          endcase
        end
      end
      ADiv: begin
        if (!rsub_w[33]) begin
          rem_d = rsub_w[32:0];
          quo_d = {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_d = rsh_w;
          quo_d = {quo_q[DivW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        // 48 iterations, counted in prod_q[5:0]; cnt is then set to all ones
        if (prod_q[5:0] == 6'(DivW - 1)) begin
          st_d = AMulB;
          cnt_d = '1;
        end
        prod_d = (prod_q[5:0] == 6'(DivW - 1)) ? prod_q : prod_q + 64'sd1;
      end
      AMulA: begin
        prod_d = 64'(res_q) * 64'(base_q);
        st_d = AMulB;
      end
      default: begin
        if (cnt_q == '1) begin
          res_d = sat64(qs_w, sat_w);
          sat_d = sat_q | sat_w;
          done_d = 1'b1;
          st_d = AIdle;
        end else begin
          res_d = satv_w;
          sat_d = sat_q | sat_w;
          if (cnt_q <= CntW'(1)) begin
            done_d = 1'b1;
            st_d = AIdle;
          end else begin
            cnt_d = cnt_q - CntW'(1);
            st_d = AMulA;
          end
        end
      end
    endcase
    if (st_q == AIdle && start_i && op_i == OP_DIV && y_i != '0) prod_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= AIdle;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; sat_q <= sat_d; dz_q <= dz_d;
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; neg_q <= neg_d;
    prod_q <= prod_d; base_q <= base_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign dz_o   = dz_q;
endmodule

[design/pese_datapath.sv]
`timescale 1ns / 1ps
module pese_datapath #(
  parameter int StackDepth = 32,
  parameter int MaxExp = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pese_pkg::dp_cmd_t  cmd_i,
  output pese_pkg::dp_sts_t  sts_o,
  input  logic [7:0]         symbol_i,
  input  logic signed [31:0] var_value_i,
  output logic signed [31:0] top_value_o,
  output logic [5:0]         depth_o,
  output logic               done_res_o,
  output logic [2:0]         status_o
);
  import pese_pkg::*;

  localparam int AddrW = $clog2(StackDepth);
  localparam int CntW  = $clog2(StackDepth + 1);

  logic [31:0] mem_q [StackDepth];
  logic [31:0] rd_q;
  logic [CntW-1:0] top_q, top_d;
  logic [7:0] sym_q;
  logic signed [31:0] var_q;
  logic signed [31:0] x_q, y_q;
  logic ufx_q, ufy_q;
  logic signed [31:0] out_val_q;
  logic [5:0] out_dep_q;
  logic out_done_q;
  logic [2:0] out_st_q;
  logic ovf_q;

  logic is_dig, is_let, is_op, is_end;
  op_e op_w;
  logic alu_done, alu_sat, alu_dz;
  logic signed [31:0] alu_res;
  logic signed [31:0] push_val;
  logic empty, full;
  logic [AddrW-1:0] rd_addr;

  assign is_dig = sym_q >= SymZero && sym_q <= SymNine;
  assign is_let = sym_q >= SymLowA && sym_q <= SymLowZ;
  assign is_op  = sym_q == SymAdd || sym_q == SymSub || sym_q == SymMul ||
                  sym_q == SymDiv || sym_q == SymPow;
  assign is_end = sym_q == SymEnd;
  assign empty  = top_q == '0;
  assign full   = top_q >= CntW'(StackDepth);
  assign rd_addr = AddrW'(top_q - CntW'(1));

  always_comb begin
    unique case (sym_q)
      SymAdd:  op_w = OP_ADD;
      SymSub:  op_w = OP_SUB;
      SymMul:  op_w = OP_MUL;
      SymDiv:  op_w = OP_DIV;
      default: op_w = OP_POW;
    endcase
  end

  pese_alu #(.MaxExp(MaxExp)) u_alu (
    .clk_i, .rst_ni,
    .start_i(cmd_i.alu_start), .op_i(op_w), .x_i(x_q), .y_i(y_q),
    .done_o(alu_done), .res_o(alu_res), .sat_o(alu_sat), .dz_o(alu_dz)
  );

  always_comb begin
    if (is_dig) push_val = 32'(sym_q - SymZero) <<< 16;
    else if (is_let) push_val = var_q;
    else push_val = alu_res;
  end

  always_comb begin
    top_d = top_q;
    if (cmd_i.clear) top_d = '0;
    else if (cmd_i.pop_x && !empty) top_d = top_q - CntW'(1);
    else if (cmd_i.push && !full) top_d = top_q + CntW'(1);
  end

  // read data holds the popped entry until the next pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) mem_q[rd_addr + AddrW'(1)] <= push_val;
    if (cmd_i.pop_x) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) top_q <= '0;
    else top_q <= top_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sym_q <= symbol_i;
      var_q <= var_value_i;
    end
    if (cmd_i.pop_x) begin
      ufx_q <= empty;
    end
    if (cmd_i.take_x) x_q <= ufx_q ? '0 : rd_q;
    if (cmd_i.take_y) begin
      y_q <= ufx_q ? '0 : rd_q;
      ufy_q <= ufx_q;
    end
    if (cmd_i.push) ovf_q <= full;
    if (cmd_i.load_out) begin
      out_dep_q <= 6'(top_q);
      out_done_q <= is_end || !(is_dig || is_let || is_op);
      if (is_dig || is_let) begin
        out_val_q <= push_val;
        out_st_q <= ovf_q ? StOverflow : StOk;
      end else if (is_op) begin
        out_val_q <= alu_res;
        if (ufx_q || ufy_q) out_st_q <= StUnderflow;
        else if (alu_dz) out_st_q <= StDivZero;
        else if (alu_sat) out_st_q <= StSat;
        else if (ovf_q) out_st_q <= StOverflow;
        else out_st_q <= StOk;
      end else if (is_end) begin
        out_val_q <= ufx_q ? '0 : rd_q;
        out_st_q <= ufx_q ? StUnderflow : StOk;
        out_dep_q <= '0;
      end else begin
        out_val_q <= '0;
        out_st_q <= StInvalid;
        out_dep_q <= '0;
      end
    end
  end

  // pop_res unused slot reuses pop_x path
  assign sts_o = '{is_push: is_dig || is_let, is_op: is_op, is_end: is_end,
                   alu_done: alu_done && !cmd_i.pop_res};
  assign top_value_o = out_val_q;
  assign depth_o = out_dep_q;
  assign done_res_o = out_done_q;
  assign status_o = out_st_q;
endmodule

[design/pese_ctrl.sv]
`timescale 1ns / 1ps
module pese_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pese_pkg::dp_cmd_t cmd_o,
  input  pese_pkg::dp_sts_t sts_i
);
  import pese_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDec   = 4'd1;
  localparam logic [3:0] SPopX  = 4'd2;
  localparam logic [3:0] SWX    = 4'd3;
  localparam logic [3:0] SPopY  = 4'd4;
  localparam logic [3:0] SWY    = 4'd5;
  localparam logic [3:0] SAlu   = 4'd6;
  localparam logic [3:0] SWait  = 4'd7;
  localparam logic [3:0] SPush  = 4'd8;
  localparam logic [3:0] SOvf   = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SEndW  = 4'd11;
  localparam logic [3:0] SEndO  = 4'd12;

  logic [3:0] st_q, st_d;
  logic ov_q, ov_d;
  logic free;

  // output register may be reloaded once the held result leaves
  assign free = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q;
    ov_d = ov_q;
    cmd_o = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load_in = 1'b1;
        st_d = SDec;
      end
      SDec: begin
        if (sts_i.is_push) st_d = SPush;
        else if (sts_i.is_op || sts_i.is_end) begin
          cmd_o.pop_x = 1'b1;
          st_d = sts_i.is_end ? SEndW : SWX;
        end else if (free) begin
          cmd_o.clear = 1'b1;
          cmd_o.load_out = 1'b1;
          st_d = SOut;
        end
      end
      SWX: begin
        st_d = SPopX;
      end
      SPopX: begin
        cmd_o.take_x = 1'b1;
        cmd_o.pop_x = 1'b1;
        st_d = SWY;
      end
      SWY: st_d = SPopY;
      SPopY: begin
        cmd_o.take_y = 1'b1;
        st_d = SAlu;
      end
      SAlu: begin
        cmd_o.alu_start = 1'b1;
        st_d = SWait;
      end
      SWait: if (sts_i.alu_done) st_d = SPush;
      SPush: begin
        cmd_o.push = 1'b1;
        st_d = SOvf;
      end
      SOvf: if (free) begin
        cmd_o.load_out = 1'b1;
        st_d = SOut;
      end
      SEndW: st_d = SEndO;
      SEndO: if (free) begin
        cmd_o.load_out = 1'b1;
        cmd_o.clear = 1'b1;
        st_d = SOut;
      end
      SOut: begin
        ov_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end
endmodule

[bench/prefix_expression_stack_evaluator_core_tb.sv]
`timescale 1ns / 1ps
module prefix_expression_stack_evaluator_core_tb;
  import pese_pkg::*;

  localparam int Depth = 32;
  localparam int MaxExp = 32;
  localparam int CycleLimit = 1000000;

  typedef struct {
    logic [31:0] top;
    logic [5:0]  depth;
    logic        done;
    logic [2:0]  st;
  } eval_result_t;

  class eval_scoreboard;
    logic signed [31:0] stk[Depth];
    int unsigned cnt;
    eval_result_t pending[$];
    int errors;
    int seen;

    function longint clamp32(longint v, inout bit s);
      if (v > 64'(QMax)) begin
        s = 1;
        return 64'(QMax);
      end
      if (v < 64'(QMin)) begin
        s = 1;
        return 64'(QMin);
      end
      return v;
    endfunction

    function longint qmul(longint a, longint b, inout bit s);
      longint p;
      longint q;
      p = a * b;
      if (p >= 0) q = p / 65536;
      else q = -((-p + 65535) / 65536);
      return clamp32(q, s);
    endfunction

    function longint arith(logic [7:0] sym, longint x, longint y, inout bit s, inout bit dz);
      longint r;
      longint n;
      case (sym)
        SymAdd: return clamp32(x + y, s);
        SymSub: return clamp32(x - y, s);
        SymMul: return qmul(x, y, s);
        SymDiv: begin
          if (y == 0) begin
            dz = 1;
            return 0;
          end
          return clamp32((x * 65536) / y, s);
        end
        default: begin
          r = x;
          if (x == 0) return 0;
          if (y == 0) return 64'(QOne);
          if (y < 2 * 65536) return x;
          n = y / 65536;
          if (n > MaxExp) n = MaxExp;
          for (longint k = 2; k <= n; k++) r = qmul(r, x, s);
          return r;
        end
      endcase
    endfunction

    function void note(logic [7:0] sym, logic signed [31:0] v);
      longint x, y, r;
      bit s, dz, ok1, ok2;
      eval_result_t e;
      s = 0;
      dz = 0;
      r = 0;
      e.st = StOk;
      e.done = 0;
      if ((sym >= SymZero && sym <= SymNine) || (sym >= SymLowA && sym <= SymLowZ)) begin
        if (sym <= SymNine) r = longint'(sym - SymZero) * 65536;
        else r = v;
        if (cnt < Depth) begin
          stk[cnt] = r[31:0];
          cnt++;
        end else e.st = StOverflow;
      end else if (sym == SymAdd || sym == SymSub || sym == SymMul || sym == SymDiv ||
                   sym == SymPow) begin
        ok1 = cnt > 0;
        x = 0;
        if (ok1) begin
          cnt--;
          x = stk[cnt];
        end
        ok2 = cnt > 0;
        y = 0;
        if (ok2) begin
          cnt--;
          y = stk[cnt];
        end
        r = arith(sym, x, y, s, dz);
        stk[cnt] = r[31:0];
        cnt++;
        if (!ok1 || !ok2) e.st = StUnderflow;
        else if (dz) e.st = StDivZero;
        else if (s) e.st = StSat;
      end else if (sym == SymEnd) begin
        if (cnt == 0) e.st = StUnderflow;
        else r = stk[cnt-1];
        cnt = 0;
        e.done = 1;
      end else begin
        e.st = StInvalid;
        cnt = 0;
        e.done = 1;
      end
      e.top = r[31:0];
      e.depth = cnt[5:0];
      pending.push_back(e);
    endfunction

    function void check(logic [47:0] d, logic u);
      eval_result_t e;
      seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result tdata=%h tuser=%b", d, u);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.top || d[37:32] !== e.depth || d[40:38] !== e.st || u !== e.done) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch #%0d: exp top=%h depth=%0d st=%0d done=%b",
                    " got top=%h depth=%0d st=%0d done=%b"},
                   seen, e.top, e.depth, e.st, e.done, d[31:0], d[37:32], d[40:38], u);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  eval_scoreboard sb = new;
  int  sent = 0;
  int  cycles = 0;
  bit  calm;
  bit  hold_done = 0;

  assign calm = (sent >= 500 && sent < 650);

  always #6 clk_i = ~clk_i;

  prefix_expression_stack_evaluator_core #(.STACK_DEPTH(Depth), .MAX_EXP(MaxExp)) u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("prefix_expression_stack_evaluator_core_tb NOT OK");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
      if (!hold_done && sb.seen >= 200) begin
        hold_done = 1;
        m_axis_tready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  task automatic send_tok(input logic [7:0] sym, input logic [31:0] v);
    while (!calm && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {v, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note(sym, v);
    sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 6)) - 3) << 16;
      2: return $urandom_range(0, 3) == 0 ? 32'h0 : 32'h8000_0000;
      default: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 0);
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return SymAdd;
      1: return SymSub;
      2: return SymMul;
      3: return SymDiv;
      default: return SymPow;
    endcase
  endfunction

  function automatic logic [7:0] SymLowB();
    return SymLowA + 8'd1;
  endfunction

  // operands and operators in right-to-left prefix order, ended by '#' unless cut short
  task automatic send_expr();
    int target, pushed, lvl;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 5);
    pushed = 0;
    lvl = 0;
    while (!(pushed == target && lvl == 1)) begin
      if (lvl >= 2 && (pushed == target || $urandom_range(0, 1))) begin
        send_tok(rand_op(), $urandom);
        lvl--;
      end else begin
        if ($urandom_range(0, 1)) send_tok(SymZero + 8'($urandom_range(0, 9)), $urandom);
        else send_tok(SymLowA + 8'($urandom_range(0, 25)), rand_value());
        pushed++;
        lvl++;
      end
      if ($urandom_range(0, 39) == 0) return;
    end
    send_tok(SymEnd, $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_tok(SymEnd, 32'hffff_ffff);
    send_tok(SymAdd, 0);
    send_tok(SymEnd, 0);
    send_tok(SymNine, 0);
    send_tok(SymZero, 0);
    send_tok(SymDiv, 0);
    send_tok(SymLowZ, 32'h7fff_ffff);
    send_tok(SymLowA, 32'h7fff_ffff);
    send_tok(SymAdd, 0);
    send_tok(SymLowA, 32'h8000_0000);
    send_tok(SymSub, 0);
    send_tok(SymLowA, 32'h0002_0000);
    send_tok(SymMul, 0);
    send_tok(SymLowB(), 32'h0020_0000);
    send_tok(SymLowA, 32'h0001_8000);
    send_tok(SymPow, 0);
    send_tok(SymEnd, 0);
    send_tok(8'h00, 32'hffff_ffff);
    send_tok(8'hff, 0);
    for (int i = 0; i < Depth + 1; i++) send_tok(SymNine, 0);
    send_tok(SymLowA, 32'h1234_5678);
    send_tok(SymPow, 0);
    send_tok(SymEnd, 0);

    while (sent < 1100) begin
      if ($urandom_range(0, 9) == 0) send_tok(8'($urandom), $urandom);
      else send_expr();
    end
    @(posedge clk_i);
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("prefix_expression_stack_evaluator_core_tb OK");
    else
      $display("prefix_expression_stack_evaluator_core_tb NOT OK");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/pese_pkg.sv
design/pese_alu.sv
design/pese_datapath.sv
design/pese_ctrl.sv
design/prefix_expression_stack_evaluator_core.sv
bench/prefix_expression_stack_evaluator_core_tb.sv
